// File: rtl/random_stub_pairing_graph_sampler_macros.svh
// Assertion macros shared by the sampler. Each macro names the clock clk and
// the reset arst_n of the module that uses it.
`ifndef RANDOM_STUB_PAIRING_GRAPH_SAMPLER_MACROS_SVH
`define RANDOM_STUB_PAIRING_GRAPH_SAMPLER_MACROS_SVH
`ifndef ASSERT_OFF
`define RSPG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RSPG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RSPG_ASSERT(lbl, prop, msg)
`define RSPG_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/rspg_pkg.sv
`timescale 1ns / 1ps
package rspg_pkg;

	localparam int DEF_MAX_STUBS = 4096;
	localparam int DEF_MAX_NODES = 1024;

	localparam int REQ_TYPE_W = 2;
	localparam int DEGREE_W   = 13;
	localparam int RAND_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int NODE_W     = 10;
	localparam int COUNT_W    = 13;

	// Request codes; every other code clears the store.
	localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_DRAW = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_LOADED   = 3'd0,
		ST_EDGE     = 3'd1,
		ST_REJECT   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_ODD      = 3'd4,
		ST_OVERFLOW = 3'd5,
		ST_CLEARED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		RD_P1   = 2'd0,
		RD_P2   = 2'd1,
		RD_TOP1 = 2'd2,
		RD_TOP2 = 2'd3
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    mod_start;
		logic    load_step;
		logic    node_inc;
		logic    clear;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_a;
		logic    cap_b;
		logic    wr_p1;
		logic    wr_p2;
		logic    shrink;
		logic    emit;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic node_full;
		logic live_zero;
		logic live_odd;
		logic load_done;
		logic load_short;
		logic mod_busy;
		logic pos_equal;
	} sts_t;

endpackage

// File: rtl/rspg_if.sv
`timescale 1ns / 1ps
interface rspg_req_if;
	logic                           valid;
	logic                           ready;
	logic [rspg_pkg::REQ_TYPE_W-1:0] req_type;
	logic [rspg_pkg::DEGREE_W-1:0]   degree;
	logic [rspg_pkg::RAND_W-1:0]     rand_first;
	logic [rspg_pkg::RAND_W-1:0]     rand_second;

	modport source (output valid, req_type, degree, rand_first, rand_second, input ready);
	modport sink (input valid, req_type, degree, rand_first, rand_second, output ready);
endinterface

interface rspg_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rspg_pkg::STATUS_W-1:0] status;
	logic [rspg_pkg::NODE_W-1:0]   node_low;
	logic [rspg_pkg::NODE_W-1:0]   node_high;
	logic [rspg_pkg::COUNT_W-1:0]  stubs_left;
	logic                          all_paired;

	modport source (output valid, status, node_low, node_high, stubs_left, all_paired,
		input ready);
	modport sink (input valid, status, node_low, node_high, stubs_left, all_paired,
		output ready);
endinterface

// File: rtl/rspg_mod.sv
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
module rspg_mod #(
	parameter int DIV_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rspg_pkg::RAND_W-1:0] dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        busy,
	output logic [DIV_W-1:0]            rem
);
	localparam int CNT_W = $clog2(rspg_pkg::RAND_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [rspg_pkg::RAND_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, dvd_q[rspg_pkg::RAND_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(rspg_pkg::RAND_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rspg_pkg::RAND_W-2:0], 1'b0};
			rem_q <= ge ? DIV_W'(diff) : DIV_W'(shifted);
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;
endmodule

// File: rtl/rspg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for load, draw and clear requests.
module rspg_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [rspg_pkg::REQ_TYPE_W-1:0] req_type,
	output logic                            req_ready,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  rspg_pkg::sts_t                  sts,
	output rspg_pkg::cmd_t                  cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MOD,
		S_RD_B,
		S_RD_T1,
		S_WR_1,
		S_RD_T2,
		S_WR_2,
		S_EMIT
	} state_t;

	state_t            state_q, state_d;
	rspg_pkg::status_t status_q, status_d;
	logic              out_valid_q;
	logic              accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		state_d    = state_q;
		status_d   = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (req_type)
						rspg_pkg::REQ_LOAD: begin
							if (sts.node_full) begin
								status_d = rspg_pkg::ST_OVERFLOW;
								state_d  = S_EMIT;
							end else begin
								state_d = S_LOAD;
							end
						end
						rspg_pkg::REQ_DRAW: begin
							if (sts.live_zero) begin
								status_d = rspg_pkg::ST_EMPTY;
								state_d  = S_EMIT;
							end else if (sts.live_odd) begin
								status_d = rspg_pkg::ST_ODD;
								state_d  = S_EMIT;
							end else begin
								cmd.mod_start = 1'b1;
								state_d       = S_MOD;
							end
						end
						default: begin
							cmd.clear = 1'b1;
							status_d  = rspg_pkg::ST_CLEARED;
							state_d   = S_EMIT;
						end
					endcase
				end
			end
			S_LOAD: begin
				if (sts.load_done) begin
					cmd.node_inc = 1'b1;
					status_d = sts.load_short ? rspg_pkg::ST_OVERFLOW : rspg_pkg::ST_LOADED;
					state_d  = S_EMIT;
				end else begin
					cmd.load_step = 1'b1;
				end
			end
			S_MOD: begin
				if (!sts.mod_busy) begin
					if (sts.pos_equal) begin
						status_d = rspg_pkg::ST_REJECT;
						state_d  = S_EMIT;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = rspg_pkg::RD_P1;
						state_d    = S_RD_B;
					end
				end
			end
			S_RD_B: begin
				cmd.cap_a  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rspg_pkg::RD_P2;
				state_d    = S_RD_T1;
			end
			S_RD_T1: begin
				cmd.cap_b  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rspg_pkg::RD_TOP1;
				state_d    = S_WR_1;
			end
			S_WR_1: begin
				cmd.wr_p1 = 1'b1;
				state_d   = S_RD_T2;
			end
			S_RD_T2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rspg_pkg::RD_TOP2;
				state_d    = S_WR_2;
			end
			S_WR_2: begin
				cmd.wr_p2  = 1'b1;
				cmd.shrink = 1'b1;
				status_d   = rspg_pkg::ST_EDGE;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= rspg_pkg::ST_LOADED;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: rtl/rspg_dp.sv
`timescale 1ns / 1ps
// Stub store, counters, remainder units and result register.
module rspg_dp #(
	parameter int MAX_STUBS = rspg_pkg::DEF_MAX_STUBS,
	parameter int MAX_NODES = rspg_pkg::DEF_MAX_NODES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rspg_pkg::DEGREE_W-1:0] degree,
	input  logic [rspg_pkg::RAND_W-1:0]   rand_first,
	input  logic [rspg_pkg::RAND_W-1:0]   rand_second,
	input  rspg_pkg::cmd_t                cmd,
	output rspg_pkg::sts_t                sts,
	output logic [rspg_pkg::STATUS_W-1:0] status,
	output logic [rspg_pkg::NODE_W-1:0]   node_low,
	output logic [rspg_pkg::NODE_W-1:0]   node_high,
	output logic [rspg_pkg::COUNT_W-1:0]  stubs_left,
	output logic                          all_paired
);
	localparam int AW  = $clog2(MAX_STUBS);
	localparam int LW  = $clog2(MAX_STUBS + 1);
	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int CW  = (LW > rspg_pkg::DEGREE_W) ? LW : rspg_pkg::DEGREE_W;

	logic [NW-1:0]  stub_mem_q [MAX_STUBS];
	logic [NW-1:0]  rdata_q;
	logic [LW-1:0]  live_q;
	logic [NCW-1:0] nodes_q;
	logic [LW-1:0]  remain_q;
	logic           short_q;
	logic [NW-1:0]  a_q, lo_q, hi_q;

	rspg_pkg::status_t res_status_q;
	logic [rspg_pkg::NODE_W-1:0]  res_low_q, res_high_q;
	logic [rspg_pkg::COUNT_W-1:0] res_left_q;
	logic                         res_paired_q;

	logic [LW-1:0] room, take;
	logic          over;
	logic          mod1_busy, mod2_busy;
	logic [LW-1:0] rem1, rem2;
	logic [AW-1:0] p1, p2, raddr, waddr;
	logic [NW-1:0] wdata;
	logic          wen;
	logic          is_edge;

	// Load admission: clip the degree to the free room in the store.
	assign room = LW'(MAX_STUBS) - live_q;
	assign over = CW'(degree) > CW'(room);
	assign take = over ? room : LW'(degree);

	rspg_mod #(.DIV_W(LW)) u_mod1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (rand_first),
		.divisor  (live_q),
		.busy     (mod1_busy),
		.rem      (rem1)
	);

	rspg_mod #(.DIV_W(LW)) u_mod2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (rand_second),
		.divisor  (live_q - LW'(1)),
		.busy     (mod2_busy),
		.rem      (rem2)
	);

	assign p1 = AW'(rem1);
	assign p2 = AW'(rem2);

	always_comb begin
		case (cmd.rd_sel)
			rspg_pkg::RD_P1:   raddr = p1;
			rspg_pkg::RD_P2:   raddr = p2;
			rspg_pkg::RD_TOP1: raddr = AW'(live_q - LW'(1));
			rspg_pkg::RD_TOP2: raddr = AW'(live_q - LW'(2));
			default:           raddr = p1;
		endcase
	end

	always_comb begin
		wen   = cmd.load_step || cmd.wr_p1 || cmd.wr_p2;
		waddr = p2;
		wdata = rdata_q;
		if (cmd.load_step) begin
			waddr = AW'(live_q);
			wdata = NW'(nodes_q);
		end else if (cmd.wr_p1) begin
			waddr = p1;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			stub_mem_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= stub_mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			nodes_q <= '0;
		end else begin
			if (cmd.clear) begin
				live_q <= '0;
			end else if (cmd.load_step) begin
				live_q <= live_q + LW'(1);
			end else if (cmd.shrink) begin
				live_q <= live_q - LW'(2);
			end
			if (cmd.clear) begin
				nodes_q <= '0;
			end else if (cmd.node_inc) begin
				nodes_q <= nodes_q + NCW'(1);
			end
		end
	end

	assign is_edge = (cmd.status == rspg_pkg::ST_EDGE);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			remain_q <= take;
			short_q  <= over;
		end else if (cmd.load_step) begin
			remain_q <= remain_q - LW'(1);
		end
		if (cmd.cap_a) begin
			a_q <= rdata_q;
		end
		if (cmd.cap_b) begin
			lo_q <= (a_q > rdata_q) ? rdata_q : a_q;
			hi_q <= (a_q > rdata_q) ? a_q : rdata_q;
		end
		if (cmd.emit) begin
			res_status_q <= cmd.status;
			res_low_q    <= is_edge ? rspg_pkg::NODE_W'(lo_q) : '0;
			res_high_q   <= is_edge ? rspg_pkg::NODE_W'(hi_q) : '0;
			res_left_q   <= rspg_pkg::COUNT_W'(live_q);
			res_paired_q <= is_edge && (live_q == '0);
		end
	end

	assign sts.node_full  = (nodes_q >= NCW'(MAX_NODES));
	assign sts.live_zero  = (live_q == '0);
	assign sts.live_odd   = live_q[0];
	assign sts.load_done  = (remain_q == '0);
	assign sts.load_short = short_q;
	assign sts.mod_busy   = mod1_busy || mod2_busy;
	assign sts.pos_equal  = (rem1 == rem2);

	assign status     = res_status_q;
	assign node_low   = res_low_q;
	assign node_high  = res_high_q;
	assign stubs_left = res_left_q;
	assign all_paired = res_paired_q;
endmodule

// File: rtl/random_stub_pairing_graph_sampler.sv
`timescale 1ns / 1ps
// Channel  Dir  Carries
// -------  ---  -----------------------------------------------------------
// req      in   req_type, degree, rand_first, rand_second (valid/ready)
// rsp      out  status, node_low, node_high, stubs_left, all_paired
//
// One request is worked at a time; the result register lets the next request
// enter while the previous result waits. A clear, a rejected load or a draw on
// an empty or odd store goes straight to the result. A load appends its d
// stubs one store write per cycle. A draw first runs the two parallel
// bit-serial remainder units, then one store port sequence of reads and
// writes. Reset clears the counts at once; the store is not cleared and
// needs no sweep. A stalled rsp holds the finished result and delays only
// the following result.
`include "random_stub_pairing_graph_sampler_macros.svh"

module random_stub_pairing_graph_sampler #(
	parameter int MAX_STUBS = rspg_pkg::DEF_MAX_STUBS,
	parameter int MAX_NODES = rspg_pkg::DEF_MAX_NODES
) (
	input logic       clk,
	input logic       arst_n,
	rspg_req_if.sink   req,
	rspg_rsp_if.source rsp
);
	// Commands from the sequencer to the datapath, and flags coming back.
	rspg_pkg::cmd_t cmd;
	rspg_pkg::sts_t sts;

	// The sequencer owns both handshakes; the datapath owns all payload.
	rspg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the stub store, the live and node counts, the two
	// remainder units that pick stub positions, and the result register.
	rspg_dp #(
		.MAX_STUBS (MAX_STUBS),
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.degree      (req.degree),
		.rand_first  (req.rand_first),
		.rand_second (req.rand_second),
		.cmd         (cmd),
		.sts         (sts),
		.status      (rsp.status),
		.node_low    (rsp.node_low),
		.node_high   (rsp.node_high),
		.stubs_left  (rsp.stubs_left),
		.all_paired  (rsp.all_paired)
	);

	// The remainder units only start on an accepted draw request.
	`RSPG_ASSERT_IMPL(a_mod_start_on_accept, cmd.mod_start, req.valid && req.ready, "remainder start without accepted request")
	// No stub is appended once the node limit is reached.
	`RSPG_ASSERT_IMPL(a_no_load_when_full, cmd.load_step, !sts.node_full, "stub appended past node limit")
	// Only an edge can leave the store fully paired.
	`RSPG_ASSERT_IMPL(a_paired_is_edge, rsp.valid && rsp.all_paired, rsp.status == rspg_pkg::ST_EDGE, "all_paired without edge")
	// An emitted edge lists its smaller node first.
	`RSPG_ASSERT_IMPL(a_edge_order, rsp.valid && (rsp.status == rspg_pkg::ST_EDGE), rsp.node_low <= rsp.node_high, "edge nodes out of order")
endmodule
